// ----- src/rutss_pkg.sv -----
// ----------------------------------------------------------------------------
// rutss_pkg
// Shared types and constants for the register use tracker with spill select.
// ----------------------------------------------------------------------------
`default_nettype none

package rutss_pkg;

    // Default size of the tracked register file and of each use count.
    localparam int NUM_REGS_DEF   = 32;
    localparam int COUNT_BITS_DEF = 16;

    // Fixed field widths of the stream payloads.
    localparam int MODE_W   = 3;
    localparam int INDEX_W  = 5;
    localparam int MASK_W   = 32;
    localparam int UCOUNT_W = 16;
    localparam int STATUS_W = 2;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 32;

    // Width of the internal pick index, enough for the largest register file.
    localparam int PICK_W = 6;

    typedef enum logic [MODE_W-1:0] {
        MODE_INC    = 3'd0,
        MODE_DEC    = 3'd1,
        MODE_CLEAR  = 3'd2,
        MODE_RSTALL = 3'd3,
        MODE_FIND   = 3'd4,
        MODE_SPILL  = 3'd5
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_SAT      = 2'd1,
        ST_DEC_ZERO = 2'd2,
        ST_NONE     = 2'd3
    } status_t;

endpackage

`default_nettype wire

// ----- src/register_use_tracker_spill_select.sv -----
// A request beat moves from the input register to the result register when the result side is free.
// Throughput: one beat per cycle unless the result side stalls; the whole update
// is combinational between the input register and the result register, so
// back-to-back beats see the state left by the previous one without any stall.
// Reset: rst_n is asynchronous and active low; it clears all masks, all use
// counts and the reserved mask, and empties both pipeline registers.
// ----------------------------------------------------------------------------
// register_use_tracker_spill_select
// Tracks use counts and a use mask for a register file split into a
// general-purpose lower half and a floating-point upper half, hands out free
// registers and selects spill victims in round-robin fashion.
// ----------------------------------------------------------------------------
`default_nettype none

module register_use_tracker_spill_select
    import rutss_pkg::*;
#(
    parameter int NUM_REGS   = NUM_REGS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // Configuration write: the reserved register mask.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [MASK_W-1:0]     cfg_data,

    // Request stream.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata from bit 0: reg_index[4:0], reg_group[5], pinned_mask[37:6],
    // candidate_mask[69:38], zero fill[71:70].
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: mode[2:0].
    input  wire logic [MODE_W-1:0]     s_axis_tuser,

    // Result stream.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // tdata from bit 0: found[0], chosen_reg[5:1], use_count[21:6],
    // reg_in_use[22], status[24:23], zero fill[31:25].
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    // Lower half of the register file is the general-purpose class.
    localparam logic [NUM_REGS-1:0] LOW_CLASS =
        {NUM_REGS{1'b1}} >> (NUM_REGS - NUM_REGS / 2);

    // ------------------------------------------------------------------
    // Architectural state.
    // ------------------------------------------------------------------
    logic [MASK_W-1:0]     reserved_reg;
    logic [NUM_REGS-1:0]   used_reg;
    logic [NUM_REGS-1:0]   used_next;
    logic [NUM_REGS-1:0]   spilled_reg;
    logic [NUM_REGS-1:0]   spilled_next;
    logic [COUNT_BITS-1:0] count_reg [NUM_REGS];

    // ------------------------------------------------------------------
    // Input register. It can take a new beat in the same cycle that its
    // current beat moves on, so the stream runs at full rate unless the
    // result side stalls.
    // ------------------------------------------------------------------
    logic                in_valid_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic [INDEX_W-1:0]  index_reg;
    logic                class_reg;
    logic [MASK_W-1:0]   pinned_reg;
    logic [MASK_W-1:0]   cand_reg;

    logic                out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic advance;
    logic in_take;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            mode_reg   <= s_axis_tuser;
            index_reg  <= s_axis_tdata[4:0];
            class_reg  <= s_axis_tdata[5];
            pinned_reg <= s_axis_tdata[37:6];
            cand_reg   <= s_axis_tdata[69:38];
        end
    end

    // ------------------------------------------------------------------
    // Update logic, combinational between the input and result registers.
    // ------------------------------------------------------------------
    logic                  idx_valid;
    logic [IDX_W-1:0]      reg_ix;
    logic [COUNT_BITS-1:0] cnt_cur;
    logic [COUNT_BITS-1:0] cnt_new;
    logic                  cnt_we;
    logic                  clr_all;
    logic                  found;
    status_t               status;

    logic [NUM_REGS-1:0]   pinned_n;
    logic [NUM_REGS-1:0]   cand_n;
    logic [NUM_REGS-1:0]   resv_n;
    logic [NUM_REGS-1:0]   avail_find;
    logic [NUM_REGS-1:0]   avail_spill;
    logic [NUM_REGS-1:0]   fresh;
    logic                  spill_wrap;
    logic [NUM_REGS-1:0]   pick_mask;
    logic [NUM_REGS-1:0]   pick_onehot;
    logic [PICK_W-1:0]     pick_idx;

    // Addresses at or beyond the register file size touch nothing and read 0.
    assign idx_valid = 32'(index_reg) < 32'(NUM_REGS);
    assign reg_ix    = IDX_W'(index_reg);
    assign cnt_cur   = idx_valid ? count_reg[reg_ix] : '0;

    assign pinned_n = NUM_REGS'(pinned_reg);
    assign cand_n   = NUM_REGS'(cand_reg);
    assign resv_n   = NUM_REGS'(reserved_reg);

    // Find free looks at one class, skipping used and pinned registers.
    assign avail_find = (class_reg ? ~LOW_CLASS : LOW_CLASS) & ~used_reg & ~pinned_n;

    // Spill select walks the eligible set round robin: registers spilled
    // recently are skipped until every eligible one has had its turn, then
    // the history wraps and the walk starts over.
    assign avail_spill = cand_n & ~(pinned_n | resv_n);
    assign spill_wrap  = (avail_spill & ~spilled_reg) == '0;
    assign fresh       = spill_wrap ? avail_spill : (avail_spill & ~spilled_reg);

    // One priority encoder serves both picking modes.
    assign pick_mask   = (mode_reg == MODE_FIND) ? avail_find : fresh;
    assign pick_onehot = pick_mask & (~pick_mask + NUM_REGS'(1));

    always_comb
    begin
        pick_idx = '0;
        for (int i = NUM_REGS - 1; i >= 0; i--)
        begin
            if (pick_mask[i])
            begin
                pick_idx = PICK_W'(i);
            end
        end
    end

    always_comb
    begin
        used_next    = used_reg;
        spilled_next = spilled_reg;
        cnt_new      = cnt_cur;
        cnt_we       = 1'b0;
        clr_all      = 1'b0;
        found        = 1'b0;
        status       = ST_OK;
        case (mode_t'(mode_reg))
            MODE_INC:
            begin
                if (idx_valid)
                begin
                    used_next[reg_ix] = 1'b1;
                    if (cnt_cur == CNT_MAX)
                    begin
                        status = ST_SAT;
                    end
                    else
                    begin
                        cnt_new = cnt_cur + 1'b1;
                        cnt_we  = 1'b1;
                    end
                end
            end
            MODE_DEC:
            begin
                if (idx_valid)
                begin
                    if (cnt_cur == '0)
                    begin
                        status = ST_DEC_ZERO;
                    end
                    else
                    begin
                        cnt_new = cnt_cur - 1'b1;
                        cnt_we  = 1'b1;
                        if (cnt_new == '0)
                        begin
                            used_next[reg_ix] = 1'b0;
                        end
                    end
                end
            end
            MODE_CLEAR:
            begin
                if (idx_valid)
                begin
                    cnt_new           = '0;
                    cnt_we            = 1'b1;
                    used_next[reg_ix] = 1'b0;
                end
            end
            MODE_RSTALL:
            begin
                // The spill history survives a reset-all.
                clr_all   = 1'b1;
                cnt_new   = '0;
                used_next = resv_n;
            end
            MODE_FIND:
            begin
                if (avail_find == '0)
                begin
                    status = ST_NONE;
                end
                else
                begin
                    found = 1'b1;
                end
            end
            MODE_SPILL:
            begin
                if (avail_spill == '0)
                begin
                    status = ST_NONE;
                end
                else
                begin
                    found        = 1'b1;
                    spilled_next = (spill_wrap ? '0 : spilled_reg) | pick_onehot;
                end
            end
            default:
            begin
                // Unused mode codes leave everything as it is.
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State: reserved mask on a config write, the rest when a beat enters the result register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            reserved_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            spilled_reg <= '0;
        end
        else if (advance)
        begin
            used_reg    <= used_next;
            spilled_reg <= spilled_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else if (advance && clr_all)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else if (advance && cnt_we)
        begin
            count_reg[reg_ix] <= cnt_new;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    logic [OUT_DATA_W-1:0] out_data_next;

    always_comb
    begin
        out_data_next        = '0;
        out_data_next[0]     = found;
        out_data_next[5:1]   = found ? INDEX_W'(pick_idx) : '0;
        out_data_next[21:6]  = idx_valid ? UCOUNT_W'(cnt_new) : '0;
        out_data_next[22]    = idx_valid ? used_next[reg_ix] : 1'b0;
        out_data_next[24:23] = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ----- src/rutss_chk.sv -----
// ----------------------------------------------------------------------------
// rutss_chk
// Port-level checks for the register use tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rutss_chk
    import rutss_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // A pick always reports success.
    a_found_ok : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[24:23] == ST_OK)
        else $error("found set with a non-ok status");

    // Without a pick the chosen register reads as zero.
    a_no_pick_zero : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[5:1] == '0)
        else $error("chosen register nonzero without a pick");

    // A decrement at zero leaves a zero count. The use bit may still be set,
    // since reset-all marks reserved registers as used with a zero count.
    a_dec_zero : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[24:23] == ST_DEC_ZERO
            |-> m_axis_tdata[21:6] == '0)
        else $error("decrement at zero with a live count");

    // A stalled result beat holds its data.
    a_hold : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

endmodule

bind register_use_tracker_spill_select rutss_chk u_rutss_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
